// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by range_frame_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RFP_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define RFP_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hw/rtl/rfp_pkg.sv =====
// Types, character codes and constants of the range frame parser.
package rfp_pkg;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_ANGLE = 2'd1,
		PH_RANGE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SUB_INT   = 2'd0,
		SUB_FRAC  = 2'd1,
		SUB_STOP  = 2'd2
	} subphase_t;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [7:0] CH_START = 8'h62; // 'b'
	localparam logic [7:0] CH_SEP   = 8'h2c; // ','
	localparam logic [7:0] CH_END   = 8'h65; // 'e'
	localparam logic [7:0] CH_POINT = 8'h2e; // '.'
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;

	localparam int POW10_W = 20;

	function automatic logic [POW10_W-1:0] pow10(input logic [2:0] n);
		logic [POW10_W-1:0] r;
		unique case (n)
			3'd0:    r = POW10_W'(1);
			3'd1:    r = POW10_W'(10);
			3'd2:    r = POW10_W'(100);
			3'd3:    r = POW10_W'(1000);
			3'd4:    r = POW10_W'(10000);
			3'd5:    r = POW10_W'(100000);
			3'd6:    r = POW10_W'(1000000);
			default: r = POW10_W'(0);
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/range_frame_parser.sv =====
// Range frame parser: serial frame decoder with a per-angle range store.
//
// One input channel (item_valid/item_ready) carries either a received
// serial byte (action 0) or a read request (action 1, query_angle). Bytes
// drive the frame parser: it hunts for 'b', reads the angle up to ',' and
// the range up to 'e', then writes the range into the store entry of that
// angle if below ANGLE_COUNT. Bytes produce no result. A read request
// clamps its angle to the store and returns one result (range_milli,
// angle_used) on the result channel (result_valid/result_ready).
// Throughput: one item per cycle while item_ready is high. Read path: the
// store is read into the read-stage register at the accepting edge and the
// result register loads from it when the read stage advances.
// A read accepted right after the closing 'e' sees that frame's write.
// Reset: parser state clears at once; the store is then zeroed by a
// clearing pass over all ANGLE_COUNT entries (360 by default), one
// entry per cycle, during which item_ready stays low.
// Stall: while result_ready is low the result register holds; one more
// read waits in the read stage, after which item_ready falls.
`include "assert_macros.svh"

module range_frame_parser #(
	parameter int ANGLE_COUNT     = 360,
	parameter int FRACTION_DIGITS = 3,
	parameter int RANGE_WIDTH     = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic                   action,
	input  logic [7:0]             rx_byte,
	input  logic signed [15:0]     query_angle,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [RANGE_WIDTH-1:0] range_milli,
	output logic [((ANGLE_COUNT > 1) ? $clog2(ANGLE_COUNT) : 1)-1:0] angle_used
);

	localparam int AW   = (ANGLE_COUNT > 1) ? $clog2(ANGLE_COUNT) : 1;
	localparam int AGW  = $clog2(ANGLE_COUNT + 1);
	localparam int FCW  = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
	localparam int SW   = ((RANGE_WIDTH > 24) ? RANGE_WIDTH : 24) + 5;
	localparam logic [RANGE_WIDTH-1:0] RANGE_MAX = {RANGE_WIDTH{1'b1}};
	localparam logic [AW-1:0] LAST_ANGLE = AW'(ANGLE_COUNT - 1);

	rfp_pkg::phase_t    phase_q, phase_d;
	rfp_pkg::subphase_t sub_q, sub_d;
	logic [AGW-1:0]         angle_acc_q, angle_acc_d;
	logic                   angle_stop_q, angle_stop_d;
	logic [RANGE_WIDTH-1:0] range_acc_q, range_acc_d;
	logic [FCW-1:0]         frac_cnt_q, frac_cnt_d;

	logic                   clearing_q;
	logic [AW-1:0]          clr_idx_q;

	logic [RANGE_WIDTH-1:0] mem [ANGLE_COUNT];
	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic [RANGE_WIDTH-1:0] mem_wd;

	logic                   valid_s1;
	logic [AW-1:0]          angle_s1;
	logic [RANGE_WIDTH-1:0] rd_data_s1;

	logic                   out_valid_q;
	logic [RANGE_WIDTH-1:0] out_range_q;
	logic [AW-1:0]          out_angle_q;

	logic                   accept, byte_acc, rd_acc, s1_adv;
	logic                   is_digit, allowed, frame_wr;
	logic [3:0]             digit;
	logic [AW-1:0]          rd_addr;
	logic [AGW+3:0]         angle_sum;
	logic [SW-1:0]          int_sum, frac_sum;
	logic [FCW-1:0]         frac_cnt_inc;
	logic [2:0]             pow_idx;

	assign s1_adv     = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !clearing_q && (!valid_s1 || s1_adv);
	assign accept     = item_valid && item_ready;
	assign byte_acc   = accept && (action == rfp_pkg::ACT_BYTE);
	assign rd_acc     = accept && (action == rfp_pkg::ACT_READ);

	assign is_digit = (rx_byte >= rfp_pkg::CH_ZERO) && (rx_byte <= rfp_pkg::CH_NINE);
	assign allowed  = is_digit || (rx_byte == rfp_pkg::CH_POINT)
		|| (rx_byte == rfp_pkg::CH_SEP)
		|| ((rx_byte >= rfp_pkg::CH_LOW_A) && (rx_byte <= rfp_pkg::CH_LOW_Z));
	assign digit    = rx_byte[3:0];

	assign angle_sum    = (AGW+4)'(angle_acc_q) * (AGW+4)'(10) + (AGW+4)'(digit);
	assign int_sum      = SW'(range_acc_q) * SW'(10)
		+ SW'(digit) * SW'(rfp_pkg::pow10(3'(FRACTION_DIGITS)));
	assign frac_cnt_inc = frac_cnt_q + FCW'(1);
	assign pow_idx      = 3'(FRACTION_DIGITS) - 3'(frac_cnt_inc);
	assign frac_sum     = SW'(range_acc_q) + SW'(digit) * SW'(rfp_pkg::pow10(pow_idx));

	assign frame_wr = byte_acc && allowed && (phase_q == rfp_pkg::PH_RANGE)
		&& (rx_byte == rfp_pkg::CH_END) && (angle_acc_q < AGW'(ANGLE_COUNT));

	always_comb begin
		phase_d      = phase_q;
		sub_d        = sub_q;
		angle_acc_d  = angle_acc_q;
		angle_stop_d = angle_stop_q;
		range_acc_d  = range_acc_q;
		frac_cnt_d   = frac_cnt_q;
		if (byte_acc && allowed) begin
			unique case (phase_q)
				rfp_pkg::PH_HUNT: begin
					if (rx_byte == rfp_pkg::CH_START) begin
						phase_d      = rfp_pkg::PH_ANGLE;
						angle_acc_d  = '0;
						angle_stop_d = 1'b0;
					end
				end
				rfp_pkg::PH_ANGLE: begin
					priority if (rx_byte == rfp_pkg::CH_SEP) begin
						phase_d     = rfp_pkg::PH_RANGE;
						range_acc_d = '0;
						sub_d       = rfp_pkg::SUB_INT;
						frac_cnt_d  = '0;
					end else if (!angle_stop_q && is_digit) begin
						angle_acc_d = (angle_sum > (AGW+4)'(ANGLE_COUNT)) ?
							AGW'(ANGLE_COUNT) : angle_sum[AGW-1:0];
					end else begin
						angle_stop_d = 1'b1;
					end
				end
				rfp_pkg::PH_RANGE: begin
					priority if (rx_byte == rfp_pkg::CH_END) begin
						phase_d = rfp_pkg::PH_HUNT;
					end else if (is_digit) begin
						if (sub_q == rfp_pkg::SUB_INT) begin
							range_acc_d = (int_sum > SW'(RANGE_MAX)) ?
								RANGE_MAX : int_sum[RANGE_WIDTH-1:0];
						end else if (sub_q == rfp_pkg::SUB_FRAC &&
								frac_cnt_q < FCW'(FRACTION_DIGITS)) begin
							frac_cnt_d  = frac_cnt_inc;
							range_acc_d = (frac_sum > SW'(RANGE_MAX)) ?
								RANGE_MAX : frac_sum[RANGE_WIDTH-1:0];
						end
					end else if (rx_byte == rfp_pkg::CH_POINT && sub_q == rfp_pkg::SUB_INT) begin
						sub_d = rfp_pkg::SUB_FRAC;
					end else begin
						sub_d = rfp_pkg::SUB_STOP;
					end
				end
				default: phase_d = rfp_pkg::PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rfp_pkg::PH_HUNT;
			sub_q        <= rfp_pkg::SUB_INT;
			angle_acc_q  <= '0;
			angle_stop_q <= 1'b0;
			range_acc_q  <= '0;
			frac_cnt_q   <= '0;
		end else begin
			phase_q      <= phase_d;
			sub_q        <= sub_d;
			angle_acc_q  <= angle_acc_d;
			angle_stop_q <= angle_stop_d;
			range_acc_q  <= range_acc_d;
			frac_cnt_q   <= frac_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == LAST_ANGLE) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		priority if (query_angle[15]) begin
			rd_addr = '0;
		end else if ($unsigned(query_angle) > 16'(ANGLE_COUNT - 1)) begin
			rd_addr = LAST_ANGLE;
		end else begin
			rd_addr = query_angle[AW-1:0];
		end
	end

	assign mem_we = clearing_q || frame_wr;
	assign mem_wa = clearing_q ? clr_idx_q : angle_acc_q[AW-1:0];
	assign mem_wd = clearing_q ? '0 : range_acc_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_acc) begin
			rd_data_s1 <= mem[rd_addr];
			angle_s1   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_range_q <= rd_data_s1;
			out_angle_q <= angle_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign range_milli  = out_range_q;
	assign angle_used   = out_angle_q;

	`RFP_ASSERT(a_read_enters_stage, clk, arst_n, rd_acc |=> valid_s1)
	`RFP_ASSERT_NEVER(a_no_write_in_clear, clk, arst_n, clearing_q && frame_wr)
	`RFP_ASSERT_NEVER(a_angle_in_store, clk, arst_n, out_valid_q && (out_angle_q > LAST_ANGLE))
	`RFP_ASSERT(a_clear_runs_full, clk, arst_n, $fell(clearing_q) |-> ($past(clr_idx_q) == LAST_ANGLE))

endmodule
